>>> rtl/core/segtree_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segtree_pkg
// Shared constants, state and command types for the segment tree block.
// ----------------------------------------------------------------------------
package segtree_pkg;

  localparam int MAX_LEAVES = 1024;
  localparam int DEPTH      = 2 * MAX_LEAVES;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int BND_W      = ADDR_W + 1;
  localparam int N_W        = $clog2(MAX_LEAVES + 1);
  localparam int CFG_W      = 11;
  localparam int IDX_W      = 10;
  localparam int VAL_W      = 32;
  localparam int SUM_W      = 64;
  localparam int CFG_RESET  = 1024;

  typedef enum logic [0:0] {
    CMD_ADD   = 1'b0,
    CMD_QUERY = 1'b1
  } command_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LOAD,
    OP_START,
    OP_WR_LEAF,
    OP_RD_SIB,
    OP_WR_PARENT,
    OP_SHIFT,
    OP_RD_A,
    OP_RD_B,
    OP_TAKE_A,
    OP_TAKE_B
  } dp_op_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_ADD_LEAF,
    S_ADD_RD,
    S_ADD_WR,
    S_Q_TEST,
    S_Q_TAKE_A,
    S_Q_TAKE_B,
    S_DONE
  } state_t;

  typedef struct packed {
    dp_op_t op;
    logic   load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic err;
    logic is_query;
    logic k_top;
    logic a_lt_b;
    logic a_odd;
    logic b_odd;
    logic clr_last;
  } dp_status_t;

endpackage

>>> rtl/core/segtree_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segtree_dp
// Datapath: node sum memory, walk registers, accumulators and result register.
// ----------------------------------------------------------------------------
module segtree_dp (
  input  logic                                   clk,
  input  logic                                   rst,
  input  segtree_pkg::dp_cmd_t                   cmd,
  output segtree_pkg::dp_status_t                status,
  input  logic                                   cfg_wen,
  input  logic [segtree_pkg::CFG_W-1:0]          cfg_wdata,
  input  logic                                   command,
  input  logic [segtree_pkg::IDX_W-1:0]          first_index,
  input  logic [segtree_pkg::IDX_W-1:0]          last_index,
  input  logic signed [segtree_pkg::VAL_W-1:0]   add_value,
  output logic signed [segtree_pkg::SUM_W-1:0]   range_sum,
  output logic                                   error
);

  logic [segtree_pkg::SUM_W-1:0]  mem [segtree_pkg::DEPTH];
  logic [segtree_pkg::SUM_W-1:0]  rdata;
  logic [segtree_pkg::ADDR_W-1:0] addr;
  logic                           we;
  logic [segtree_pkg::SUM_W-1:0]  wdata;

  logic [segtree_pkg::CFG_W-1:0]  leaf_count;
  logic [segtree_pkg::N_W-1:0]    eff_n;
  logic                           cmd_q;
  logic [segtree_pkg::IDX_W-1:0]  lo_q;
  logic [segtree_pkg::IDX_W-1:0]  hi_q;
  logic [segtree_pkg::SUM_W-1:0]  val_q;
  logic                           err_q;
  logic [segtree_pkg::ADDR_W-1:0] k;
  logic [segtree_pkg::BND_W-1:0]  a;
  logic [segtree_pkg::BND_W-1:0]  b;
  logic [segtree_pkg::SUM_W-1:0]  cur;
  logic [segtree_pkg::SUM_W-1:0]  left;
  logic [segtree_pkg::SUM_W-1:0]  right;
  logic [segtree_pkg::ADDR_W-1:0] clr;

  logic                           err_c;
  logic [segtree_pkg::ADDR_W-1:0] a_init;
  logic [segtree_pkg::BND_W-1:0]  b_init;
  logic [segtree_pkg::BND_W-1:0]  b_dec;
  logic [segtree_pkg::SUM_W-1:0]  leaf_sum;
  logic [segtree_pkg::SUM_W-1:0]  parent_sum;

  always_comb begin
    if (32'(leaf_count) > segtree_pkg::MAX_LEAVES) begin
      eff_n = segtree_pkg::N_W'(segtree_pkg::MAX_LEAVES);
    end else begin
      eff_n = segtree_pkg::N_W'(leaf_count);
    end
  end

  always_comb begin
    if (cmd_q == segtree_pkg::CMD_ADD) begin
      err_c = 32'(lo_q) >= 32'(eff_n);
    end else begin
      err_c = (32'(hi_q) >= 32'(eff_n)) || (lo_q > hi_q);
    end
  end

  assign a_init     = segtree_pkg::ADDR_W'(32'(lo_q) + 32'(eff_n));
  assign b_init     = segtree_pkg::BND_W'(32'(hi_q) + 32'(eff_n) + 32'd1);
  assign b_dec      = b - segtree_pkg::BND_W'(1);
  assign leaf_sum   = rdata + val_q;
  assign parent_sum = cur + rdata;

  assign status.err      = err_c;
  assign status.is_query = cmd_q;
  assign status.k_top    = k == segtree_pkg::ADDR_W'(1);
  assign status.a_lt_b   = a < b;
  assign status.a_odd    = a[0];
  assign status.b_odd    = b[0];
  assign status.clr_last = clr == segtree_pkg::ADDR_W'(segtree_pkg::DEPTH - 1);

  always_comb begin
    we    = 1'b0;
    wdata = leaf_sum;
    addr  = k;
    case (cmd.op)
      segtree_pkg::OP_CLEAR: begin
        we    = 1'b1;
        wdata = '0;
        addr  = clr;
      end
      segtree_pkg::OP_START: begin
        addr = a_init;
      end
      segtree_pkg::OP_WR_LEAF: begin
        we    = 1'b1;
        wdata = leaf_sum;
        addr  = k;
      end
      segtree_pkg::OP_RD_SIB: begin
        addr = k ^ segtree_pkg::ADDR_W'(1);
      end
      segtree_pkg::OP_WR_PARENT: begin
        we    = 1'b1;
        wdata = parent_sum;
        addr  = k >> 1;
      end
      segtree_pkg::OP_RD_A: begin
        addr = a[segtree_pkg::ADDR_W-1:0];
      end
      segtree_pkg::OP_RD_B, segtree_pkg::OP_TAKE_A: begin
        addr = b_dec[segtree_pkg::ADDR_W-1:0];
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      leaf_count <= segtree_pkg::CFG_W'(segtree_pkg::CFG_RESET);
      clr        <= '0;
    end else begin
      if (cfg_wen) begin
        leaf_count <= cfg_wdata;
      end
      if (cmd.op == segtree_pkg::OP_CLEAR) begin
        clr <= clr + segtree_pkg::ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      segtree_pkg::OP_LOAD: begin
        cmd_q <= command;
        lo_q  <= first_index;
        hi_q  <= last_index;
        val_q <= {{(segtree_pkg::SUM_W - segtree_pkg::VAL_W){add_value[segtree_pkg::VAL_W-1]}},
                  add_value};
      end
      segtree_pkg::OP_START: begin
        err_q <= err_c;
        k     <= a_init;
        a     <= segtree_pkg::BND_W'(a_init);
        b     <= b_init;
        left  <= '0;
        right <= '0;
      end
      segtree_pkg::OP_WR_LEAF: begin
        cur <= leaf_sum;
      end
      segtree_pkg::OP_WR_PARENT: begin
        cur <= parent_sum;
        k   <= k >> 1;
      end
      segtree_pkg::OP_SHIFT: begin
        a <= a >> 1;
        b <= b >> 1;
      end
      segtree_pkg::OP_TAKE_A: begin
        left <= left + rdata;
        if (b[0]) begin
          a <= a + segtree_pkg::BND_W'(1);
        end else begin
          a <= (a + segtree_pkg::BND_W'(1)) >> 1;
          b <= b >> 1;
        end
      end
      segtree_pkg::OP_TAKE_B: begin
        right <= right + rdata;
        a     <= a >> 1;
        b     <= b_dec >> 1;
      end
      default: begin
      end
    endcase
    if (cmd.load_out) begin
      range_sum <= left + right;
      error     <= err_q;
    end
  end

endmodule

>>> rtl/core/segtree_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segtree_ctrl
// Controller: clearing pass, command sequencing and the result handshake.
// ----------------------------------------------------------------------------
module segtree_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  logic                    out_ready,
  output segtree_pkg::dp_cmd_t    cmd,
  input  segtree_pkg::dp_status_t status
);

  segtree_pkg::state_t state;
  segtree_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= segtree_pkg::S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next   = state;
    cmd.op       = segtree_pkg::OP_NONE;
    cmd.load_out = 1'b0;
    in_ready     = 1'b0;
    case (state)
      segtree_pkg::S_CLEAR: begin
        cmd.op = segtree_pkg::OP_CLEAR;
        if (status.clr_last) begin
          state_next = segtree_pkg::S_IDLE;
        end
      end
      segtree_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op     = segtree_pkg::OP_LOAD;
          state_next = segtree_pkg::S_CHECK;
        end
      end
      segtree_pkg::S_CHECK: begin
        cmd.op = segtree_pkg::OP_START;
        if (status.err) begin
          state_next = segtree_pkg::S_DONE;
        end else if (status.is_query) begin
          state_next = segtree_pkg::S_Q_TEST;
        end else begin
          state_next = segtree_pkg::S_ADD_LEAF;
        end
      end
      segtree_pkg::S_ADD_LEAF: begin
        cmd.op     = segtree_pkg::OP_WR_LEAF;
        state_next = segtree_pkg::S_ADD_RD;
      end
      segtree_pkg::S_ADD_RD: begin
        if (status.k_top) begin
          state_next = segtree_pkg::S_DONE;
        end else begin
          cmd.op     = segtree_pkg::OP_RD_SIB;
          state_next = segtree_pkg::S_ADD_WR;
        end
      end
      segtree_pkg::S_ADD_WR: begin
        cmd.op     = segtree_pkg::OP_WR_PARENT;
        state_next = segtree_pkg::S_ADD_RD;
      end
      segtree_pkg::S_Q_TEST: begin
        if (!status.a_lt_b) begin
          state_next = segtree_pkg::S_DONE;
        end else if (status.a_odd) begin
          cmd.op     = segtree_pkg::OP_RD_A;
          state_next = segtree_pkg::S_Q_TAKE_A;
        end else if (status.b_odd) begin
          cmd.op     = segtree_pkg::OP_RD_B;
          state_next = segtree_pkg::S_Q_TAKE_B;
        end else begin
          cmd.op = segtree_pkg::OP_SHIFT;
        end
      end
      segtree_pkg::S_Q_TAKE_A: begin
        cmd.op = segtree_pkg::OP_TAKE_A;
        if (status.b_odd) begin
          state_next = segtree_pkg::S_Q_TAKE_B;
        end else begin
          state_next = segtree_pkg::S_Q_TEST;
        end
      end
      segtree_pkg::S_Q_TAKE_B: begin
        cmd.op     = segtree_pkg::OP_TAKE_B;
        state_next = segtree_pkg::S_Q_TEST;
      end
      segtree_pkg::S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = segtree_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = segtree_pkg::S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/core/segment_tree_add_range_sum_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_tree_add_range_sum_top
// Segment tree with point add and inclusive range sum over up to 1024 leaves.
// ----------------------------------------------------------------------------
// After reset the block clears every word of its node memory and takes no
// beat until that pass is done; configuration writes are taken throughout.
// Items are handled one at a time through a single-port node memory with a
// registered read. An add walks from the leaf to the root over L levels (L = 10
// at 1024 leaves), and each level needs one sibling read and one parent write.
// A query walks up from both range bounds and at each level adds the node at
// the left bound, the node at the right bound, both or neither before moving
// up. A rejected command skips the walk. The result is then moved into the
// output register, and the next beat is taken while an earlier result still
// waits there.
module segment_tree_add_range_sum_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wen,
  input  logic [segtree_pkg::CFG_W-1:0]        cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 command,
  input  logic [segtree_pkg::IDX_W-1:0]        first_index,
  input  logic [segtree_pkg::IDX_W-1:0]        last_index,
  input  logic signed [segtree_pkg::VAL_W-1:0] add_value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [segtree_pkg::SUM_W-1:0] range_sum,
  output logic                                 error
);

  segtree_pkg::dp_cmd_t    cmd;
  segtree_pkg::dp_status_t status;

  segtree_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  segtree_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg_wen     (cfg_wen),
    .cfg_wdata   (cfg_wdata),
    .command     (command),
    .first_index (first_index),
    .last_index  (last_index),
    .add_value   (add_value),
    .range_sum   (range_sum),
    .error       (error)
  );

endmodule

>>> rtl/core/segtree_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segtree_checker
// Port-level assertions for the segment tree block, bound to the top level.
// ----------------------------------------------------------------------------
module segtree_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 in_valid,
  input logic                                 in_ready,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic signed [segtree_pkg::SUM_W-1:0] range_sum,
  input logic                                 error
);

  // A result that is not taken stays on the port unchanged.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(range_sum) && $stable(error))
    else $error("held result beat changed");

  // A rejected command never reports a nonzero sum.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && error |-> range_sum == '0)
    else $error("error beat carries a nonzero sum");

  // Work on one beat blocks the input until it is finished.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a beat is in progress");

  // Reset leaves no result pending and the memory clear keeps input closed.
  assert property (@(posedge clk)
    rst |=> !out_valid && !in_ready)
    else $error("result or ready present right after reset");

endmodule

bind segment_tree_add_range_sum_top segtree_checker u_segtree_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .range_sum (range_sum),
  .error     (error)
);
